[rtl/chks_pkg.sv]
// Shared types and constants for the chained hash key store.
package chks_pkg;

    localparam int KEY_MAX = 15;
    localparam logic [4:0] HASH_MUL = 5'd31;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_FIND   = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_UNUSED   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_INS,
        S_WALK_RD,
        S_WALK_CMP,
        S_REM_LINK,
        S_REM_FREE,
        S_REPLY
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // latch input item, reset hash count
        logic hash_step;   // fold one key byte
        logic head_rd;     // read bucket head
        logic clr_step;    // clear one bucket, bump clear pointer
        logic ins;         // write node, link into bucket, pop free stack
        logic node_rd;     // read node at cursor
        logic advance;     // prev <= cur, cur <= link
        logic unlink;      // patch head or prev link
        logic free_push;   // push cursor node on free stack
        logic reply;       // drive result
        t_status status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic hash_done;
        logic pool_empty;
        logic cur_nil;
        logic key_match;
        logic steps_out;
        t_action action;
    } t_stat;

endpackage

[rtl/chained_hash_key_store.sv]
// After acceptance the hash folds key bytes up to the zero terminator, at most KEY_BYTES,
// then the bucket head is read; find and remove then read and compare chain nodes in turn,
// and remove unlinks and frees the hit node. One item at a time; the next is taken at the
// edge ending the o_valid cycle. Hash folds one key byte per cycle; the chain walk reads
// each node and compares it. After reset a clearing pass over max(BUCKETS, NODES) entries
// holds busy high. Results appear for one cycle on o_valid; the receiver cannot stall.
module chained_hash_key_store
    import chks_pkg::*;
#(
    parameter int BUCKETS     = 256,
    parameter int NODES       = 256,
    parameter int KEY_BYTES   = 15,
    parameter int RECORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_key_first,
    input  logic [55:0] i_key_rest,
    input  logic [15:0] i_record_in,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_record_out,
    output logic [8:0]  o_entries_held
);

    t_cmd  cmd;
    t_stat stat;

    chks_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    chks_dp #(
        .BUCKETS    (BUCKETS),
        .NODES      (NODES),
        .KEY_BYTES  (KEY_BYTES),
        .RECORD_BITS(RECORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_action      (i_action),
        .i_key_first   (i_key_first),
        .i_key_rest    (i_key_rest),
        .i_record_in   (i_record_in),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_record_out  (o_record_out),
        .o_entries_held(o_entries_held)
    );

endmodule

[rtl/chks_ctrl.sv]
// Controller state machine for the chained hash key store.
module chks_ctrl
    import chks_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.status = ST_NOT_FOUND;
        busy = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_stat.hash_done) n_state = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.head_rd = 1'b1;
                case (i_stat.action)
                    ACT_INSERT: n_state = i_stat.pool_empty ? S_REPLY : S_INS;
                    ACT_FIND, ACT_REMOVE: n_state = S_WALK_RD;
                    default: n_state = S_REPLY;
                endcase
            end
            S_INS: begin
                // reply with the insert; the entry count seen with the result already includes it
                o_cmd.ins = 1'b1;
                o_cmd.reply = 1'b1;
                o_cmd.status = ST_DONE;
                n_state = S_IDLE;
            end
            S_WALK_RD: begin
                if (i_stat.cur_nil || i_stat.steps_out) begin
                    o_cmd.reply = 1'b1;
                    o_cmd.status = ST_NOT_FOUND;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.node_rd = 1'b1;
                    n_state = S_WALK_CMP;
                end
            end
            S_WALK_CMP: begin
                if (i_stat.key_match) begin
                    if (i_stat.action == ACT_REMOVE) begin
                        n_state = S_REM_LINK;
                    end else begin
                        o_cmd.reply = 1'b1;
                        o_cmd.status = ST_DONE;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_WALK_RD;
                end
            end
            S_REM_LINK: begin
                o_cmd.unlink = 1'b1;
                n_state = S_REM_FREE;
            end
            S_REM_FREE: begin
                o_cmd.free_push = 1'b1;
                o_cmd.reply = 1'b1;
                o_cmd.status = ST_DONE;
                n_state = S_IDLE;
            end
            S_REPLY: begin
                // insert outcome or unknown action
                o_cmd.reply = 1'b1;
                if (i_stat.action == ACT_INSERT)
                    o_cmd.status = i_stat.pool_empty ? ST_FULL : ST_DONE;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/chks_dp.sv]
// Datapath for the chained hash key store: hash, memories, chain walk.
module chks_dp
    import chks_pkg::*;
#(
    parameter int BUCKETS     = 256,
    parameter int NODES       = 256,
    parameter int KEY_BYTES   = 15,
    parameter int RECORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_key_first,
    input  logic [55:0] i_key_rest,
    input  logic [15:0] i_record_in,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_record_out,
    output logic [8:0]  o_entries_held
);

    localparam int BW = $clog2(BUCKETS);
    localparam int NW = $clog2(NODES);
    localparam int PW = NW + 1;                    // node index with null
    localparam logic [PW-1:0] NIL = PW'(NODES);
    localparam int KB = (KEY_BYTES < KEY_MAX) ? KEY_BYTES : KEY_MAX;
    localparam int CW = $clog2(KEY_MAX + 1);
    localparam int CLR_N = (BUCKETS > NODES) ? BUCKETS : NODES;
    localparam int CLW = $clog2(CLR_N);

    // bucket heads as memory, plus clear pass
    logic [PW-1:0] r_head_mem [BUCKETS];
    logic [NW-1:0] r_free_mem [NODES];
    logic [63:0]   r_kf_mem   [NODES];
    logic [55:0]   r_kr_mem   [NODES];
    logic [RECORD_BITS-1:0] r_rec_mem [NODES];
    logic [PW-1:0] r_link_mem [NODES];

    logic [CLW:0]  r_clr;
    t_action       r_action;
    logic [119:0]  r_key;       // shifts left as bytes are consumed
    logic [119:0]  r_nkey;      // normalized key
    logic          r_ended;
    logic [CW-1:0] r_cnt;
    logic [BW-1:0] r_hash;
    logic [RECORD_BITS-1:0] r_rec;
    logic [PW-1:0] r_cur, r_prev, r_next;
    logic [PW:0]   r_steps;
    logic [PW-1:0] r_free_cnt;
    logic [8:0]    r_total;
    logic [63:0]   r_nd_kf;
    logic [55:0]   r_nd_kr;
    logic [RECORD_BITS-1:0] r_nd_rec;
    logic [NW-1:0] r_top;
    logic          r_valid;
    logic [1:0]    r_status;
    logic [15:0]   r_rec_out;

    logic [7:0]    byte_cur;
    logic          byte_end;
    logic [BW+5:0] hash_prod;

    assign byte_cur  = r_key[119:112];
    assign byte_end  = r_ended || (byte_cur == 8'd0);
    assign hash_prod = {6'd0, r_hash} * HASH_MUL + (BW+6)'(byte_cur);

    // hash: one byte per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_key    <= {i_key_first, i_key_rest};
            r_nkey   <= '0;
            r_ended  <= 1'b0;
            r_cnt    <= '0;
            r_hash   <= '0;
            r_rec    <= i_record_in[RECORD_BITS-1:0];
        end else if (i_cmd.hash_step) begin
            r_key <= {r_key[111:0], 8'd0};
            r_cnt <= r_cnt + CW'(1);
            if (!byte_end) begin
                r_hash <= hash_prod[BW-1:0];
                r_nkey <= r_nkey | ({byte_cur, 112'd0} >> (8 * r_cnt));
            end else begin
                r_ended <= 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.hash_done  = (r_cnt == CW'(KB - 1)) || byte_end;
        o_stat.action     = r_action;
        o_stat.pool_empty = (r_free_cnt == '0);
        o_stat.cur_nil    = (r_cur == NIL);
        o_stat.steps_out  = (r_steps >= (PW+1)'(NODES));
        o_stat.key_match  = (r_nd_kf == r_nkey[119:56]) && (r_nd_kr == r_nkey[55:0]);
        o_stat.clr_done   = (r_clr == (CLW+1)'(CLR_N));
    end

    // head memory: clear pass, read, write
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            if (r_clr < (CLW+1)'(BUCKETS))
                r_head_mem[r_clr[BW-1:0]] <= NIL;
        end else if (i_cmd.ins)
            r_head_mem[r_hash] <= {1'b0, r_top};
        else if (i_cmd.unlink && r_prev == NIL)
            r_head_mem[r_hash] <= r_next;
    end

    // head read result lands in cursor; free top read with it
    always_ff @(posedge i_clk) begin
        if (i_cmd.head_rd) begin
            r_cur   <= r_head_mem[r_hash];
            r_prev  <= NIL;
            r_steps <= '0;
            r_top   <= r_free_mem[NW'(r_free_cnt - PW'(1))];
        end else if (i_cmd.advance) begin
            r_prev  <= r_cur;
            r_cur   <= r_next;
            r_steps <= r_steps + (PW+1)'(1);
        end
    end

    // node read
    always_ff @(posedge i_clk) begin
        if (i_cmd.node_rd) begin
            r_nd_kf  <= r_kf_mem[r_cur[NW-1:0]];
            r_nd_kr  <= r_kr_mem[r_cur[NW-1:0]];
            r_nd_rec <= r_rec_mem[r_cur[NW-1:0]];
            r_next   <= r_link_mem[r_cur[NW-1:0]];
        end
    end

    // node writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            r_kf_mem[r_top]  <= r_nkey[119:56];
            r_kr_mem[r_top]  <= r_nkey[55:0];
            r_rec_mem[r_top] <= r_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins)
            r_link_mem[r_top] <= r_cur;
        else if (i_cmd.unlink && r_prev != NIL)
            r_link_mem[r_prev[NW-1:0]] <= r_next;
    end

    // free stack: filled during clear pass, pushed on remove
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step && r_clr < (CLW+1)'(NODES))
            r_free_mem[r_clr[NW-1:0]] <= r_clr[NW-1:0];
        else if (i_cmd.free_push)
            r_free_mem[r_free_cnt[NW-1:0]] <= r_cur[NW-1:0];
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_free_cnt <= NIL;
            r_total    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.reply;
            if (i_cmd.clr_step) r_clr <= r_clr + (CLW+1)'(1);
            if (i_cmd.ins) begin
                r_free_cnt <= r_free_cnt - PW'(1);
                r_total    <= r_total + 9'd1;
            end else if (i_cmd.free_push) begin
                r_free_cnt <= r_free_cnt + PW'(1);
                r_total    <= r_total - 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.reply) begin
            r_status  <= i_cmd.status;
            r_rec_out <= (i_cmd.status == ST_DONE && r_action != ACT_INSERT)
                       ? 16'(r_nd_rec) : 16'd0;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_record_out   = r_rec_out;
    assign o_entries_held = r_total;

endmodule

[tb/chained_hash_key_store_tb.sv]
// Testbench for the chained hash key store: directed table, pool fill and overflow, then random traffic, scoreboarded.
module chained_hash_key_store_tb;
    import chks_pkg::*;

    localparam int NB = 256;
    localparam int NN = 256;
    localparam int LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_action = ACT_INSERT;
    logic [63:0] i_key_first = '0;
    logic [55:0] i_key_rest = '0;
    logic [15:0] i_record_in = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_record_out;
    logic [8:0]  o_entries_held;

    chained_hash_key_store DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] rec;
        logic [8:0]  held;
    } t_reply;

    // model of the store
    logic [8:0]  head_tbl [NB];
    logic [63:0] nkf [NN];
    logic [55:0] nkr [NN];
    logic [15:0] nrec [NN];
    logic [8:0]  nlink [NN];
    logic [7:0]  free_stk [NN];
    int unsigned free_cnt, held_cnt;

    t_reply replies_due [$];
    int errors = 0;
    int cycles = 0;

    // key pool makes finds and removes likely to hit stored entries
    logic [63:0] pool_kf [16];
    logic [55:0] pool_kr [16];

    function automatic t_reply store_step(t_action act, logic [63:0] kf0, logic [55:0] kr0,
                                          logic [15:0] rec);
        t_reply r;
        logic [63:0] kf;
        logic [55:0] kr;
        logic [7:0] b;
        int unsigned h, p, prev, steps, n;
        bit stop;
        kf = '0; kr = '0; h = 0; stop = 0;
        for (int i = 0; i < KEY_MAX; i++) begin
            b = (i < 8) ? kf0[63-8*i -: 8] : kr0[55-8*(i-8) -: 8];
            if (b == 8'd0) stop = 1;
            if (!stop) begin
                h = h * 31 + b;
                if (i < 8) kf[63-8*i -: 8] = b; else kr[55-8*(i-8) -: 8] = b;
            end
        end
        h = h % NB;
        r.status = ST_NOT_FOUND;
        r.rec = '0;
        if (act == ACT_INSERT) begin
            if (free_cnt == 0) r.status = ST_FULL;
            else begin
                free_cnt--;
                n = free_stk[free_cnt];
                nkf[n] = kf; nkr[n] = kr; nrec[n] = rec;
                nlink[n] = head_tbl[h];
                head_tbl[h] = 9'(n);
                held_cnt++;
                r.status = ST_DONE;
            end
        end else if (act == ACT_FIND || act == ACT_REMOVE) begin
            p = head_tbl[h]; prev = NN; steps = 0;
            while (p < NN && steps < NN && !(nkf[p] == kf && nkr[p] == kr)) begin
                prev = p; p = nlink[p]; steps++;
            end
            if (p < NN && steps < NN) begin
                r.status = ST_DONE;
                r.rec = nrec[p];
                if (act == ACT_REMOVE) begin
                    if (prev == NN) head_tbl[h] = nlink[p];
                    else nlink[prev] = nlink[p];
                    nlink[p] = 9'(NN);
                    if (free_cnt < NN) begin
                        free_stk[free_cnt] = 8'(p);
                        free_cnt++;
                    end
                    if (held_cnt > 0) held_cnt--;
                end
            end
        end
        r.held = held_cnt[8:0];
        return r;
    endfunction

    // check results
    always @(posedge i_clk) begin
        t_reply got, want;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            got = '{o_status, o_record_out, o_entries_held};
            if (replies_due.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10) $display("unexpected result %p", got);
            end else begin
                want = replies_due.pop_front();
                if (got !== want) begin
                    errors <= errors + 1;
                    if (errors < 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // send one item and wait for acceptance; start stays high for a following item
    task automatic send_item(t_action act, logic [63:0] kf, logic [55:0] kr,
                             logic [15:0] rec, bit fixed, t_reply fixed_reply);
        t_reply r;
        i_action <= act; i_key_first <= kf; i_key_rest <= kr; i_record_in <= rec;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = store_step(act, kf, kr, rec);
        // typed row must agree with the model
        if (fixed && r !== fixed_reply) begin
            errors++;
            $display("table row disagrees: typed %p model %p", fixed_reply, r);
        end
        replies_due.push_back(r);
    endtask

    function automatic logic [63:0] rand_kf();
        return {$urandom, $urandom};
    endfunction

    // short key with random length, sometimes long
    task automatic make_key(output logic [63:0] kf, output logic [55:0] kr);
        int len;
        kf = '0; kr = '0;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 4);
        for (int i = 0; i < len; i++) begin
            if (i < 8) kf[63-8*i -: 8] = 8'($urandom_range(1, 255));
            else kr[55-8*(i-8) -: 8] = 8'($urandom_range(1, 255));
        end
        // junk after the terminator now and then
        if ($urandom_range(0, 7) == 0) begin
            kf = kf | (len < 8 ? (rand_kf() >> (8 * (len + 1))) : 64'd0);
            kr = kr | 56'({$urandom, $urandom} >> 8);
            if (len < 15) begin
                if (len < 8) kf[63-8*len -: 8] = 8'd0; else kr[55-8*(len-8) -: 8] = 8'd0;
            end
        end
    endtask

    typedef struct {
        t_action act;
        logic [63:0] kf;
        logic [55:0] kr;
        logic [15:0] rec;
        bit fixed;
        t_reply r;
    } t_row;

    t_row dir_tbl [] = '{
        '{ACT_FIND,   64'h41_00_00_00_00_00_00_00, 56'd0, 16'd0, 1, '{ST_NOT_FOUND, 16'd0, 9'd0}},
        '{ACT_REMOVE, 64'd0, 56'd0, 16'd0, 1, '{ST_NOT_FOUND, 16'd0, 9'd0}},
        '{ACT_NONE,   '1, '1, '1, 1, '{ST_NOT_FOUND, 16'd0, 9'd0}},
        '{ACT_INSERT, 64'd0, 56'd0, 16'hFFFF, 1, '{ST_DONE, 16'd0, 9'd1}},
        '{ACT_FIND,   64'd0, 56'hABCDEF, 16'd0, 1, '{ST_DONE, 16'hFFFF, 9'd1}},
        '{ACT_INSERT, '1, '1, 16'h1234, 1, '{ST_DONE, 16'd0, 9'd2}},
        '{ACT_FIND,   '1, '1, 16'd0, 1, '{ST_DONE, 16'h1234, 9'd2}},
        '{ACT_INSERT, '1, 56'd0, 16'h0001, 1, '{ST_DONE, 16'd0, 9'd3}},
        '{ACT_INSERT, '1, 56'd0, 16'h0002, 1, '{ST_DONE, 16'd0, 9'd4}},
        '{ACT_FIND,   '1, 56'd0, 16'd0, 1, '{ST_DONE, 16'h0002, 9'd4}},
        '{ACT_REMOVE, '1, 56'd0, 16'd0, 1, '{ST_DONE, 16'h0002, 9'd3}},
        '{ACT_FIND,   '1, 56'd0, 16'd0, 1, '{ST_DONE, 16'h0001, 9'd3}},
        '{ACT_NONE,   '1, 56'd0, 16'd0, 1, '{ST_NOT_FOUND, 16'd0, 9'd3}},
        '{ACT_INSERT, 64'h4142_0000_0000_0000, 56'd0, 16'h00AA, 0, '{0, 0, 0}},
        '{ACT_INSERT, 64'h4241_0000_0000_0000, 56'd0, 16'h00BB, 0, '{0, 0, 0}},
        '{ACT_FIND,   64'h4142_00FF_FFFF_FFFF, 56'h123456, 16'd0, 0, '{0, 0, 0}},
        '{ACT_REMOVE, 64'h4241_0000_0000_0000, 56'd0, 16'd0, 0, '{0, 0, 0}},
        '{ACT_REMOVE, '1, '1, 16'd0, 1, '{ST_DONE, 16'h1234, 9'd3}},
        '{ACT_REMOVE, 64'd0, 56'd0, 16'd0, 1, '{ST_DONE, 16'hFFFF, 9'd2}}
    };

    task automatic wait_drained();
        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        t_action act;
        logic [63:0] kf;
        logic [55:0] kr;
        int burst, k, sent, gap;
        for (int i = 0; i < NB; i++) head_tbl[i] = 9'(NN);
        for (int i = 0; i < NN; i++) begin
            free_stk[i] = 8'(i); nlink[i] = 9'(NN);
        end
        free_cnt = NN; held_cnt = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i])
            send_item(dir_tbl[i].act, dir_tbl[i].kf, dir_tbl[i].kr, dir_tbl[i].rec,
                      dir_tbl[i].fixed, dir_tbl[i].r);
        wait_drained();

        // fill the pool to full, then overflow it
        for (int i = 0; i < NN + 4; i++) begin
            make_key(kf, kr);
            send_item(ACT_INSERT, kf, kr, 16'($urandom), 0, '0);
        end
        wait_drained();

        for (int i = 0; i < 16; i++) make_key(pool_kf[i], pool_kr[i]);
        sent = 0;
        while (sent < 520) begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst; j++) begin
                k = $urandom_range(0, 15);
                if ($urandom_range(0, 5) == 0) make_key(kf, kr);
                else begin kf = pool_kf[k]; kr = pool_kr[k]; end
                case ($urandom_range(0, 19))
                    0:          act = ACT_NONE;
                    1,2,3,4,5,6,7: act = ACT_INSERT;
                    8,9,10,11,12: act = ACT_FIND;
                    default:    act = ACT_REMOVE;
                endcase
                send_item(act, kf, kr, 16'($urandom), 0, '0);
                sent++;
            end
            if (sent % 200 < 20) wait_drained();
            else begin
                gap = $urandom_range(0, 12);
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        wait_drained();
        if (errors == 0 && replies_due.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[files.f]
rtl/chks_pkg.sv
rtl/chks_ctrl.sv
rtl/chks_dp.sv
rtl/chained_hash_key_store.sv
tb/chained_hash_key_store_tb.sv
